### hdl/earliest_deadline_timer_table_core_macros.svh
// ----------------------------------------------------------------------------
// earliest deadline timer table: assertion macros
// shared property wrappers, sampled on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef EARLIEST_DEADLINE_TIMER_TABLE_CORE_MACROS_SVH
`define EARLIEST_DEADLINE_TIMER_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define EDTT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edtt check failed");

// next-cycle implication
`define EDTT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edtt check failed");

`endif

### hdl/edtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtt_pkg
// types, codes and defaults shared by the earliest deadline timer table
// ----------------------------------------------------------------------------
package edtt_pkg;

	// fixed port field widths
	localparam int CMD_W    = 2;
	localparam int LINE_W   = 26;
	localparam int LAT_W    = 16;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 5;

	// parameter defaults
	localparam int ENTRIES_DEF      = 16;
	localparam int LINE_BITS_DEF    = 26;
	localparam int TIME_BITS_DEF    = 48;
	localparam int LATENCY_BITS_DEF = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_DISARM = 2'd2
	} edtt_cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 3'd0,
		STS_DUP     = 3'd1,
		STS_FULL    = 3'd2,
		STS_ZERO    = 3'd3,
		STS_MISSING = 3'd4
	} edtt_status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DUE
	} edtt_state_e;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [LINE_W-1:0] line_num;
		logic [LAT_W-1:0]  latency;
	} in_item_t;

	typedef struct packed {
		logic                ready_res;
		logic [LINE_W-1:0]   ready_address;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} out_item_t;

	// slot store controls
	typedef struct packed {
		logic rd;   // registered read at rd_addr
		logic wr;   // write line and expiry, mark slot armed
		logic clr;  // mark slot free
	} edtt_mem_ctl_t;

endpackage

### hdl/earliest_deadline_timer_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_deadline_timer_table_core
// table of armed line timers with a free-running tick counter; reports the
// earliest expiry after every item
// ----------------------------------------------------------------------------
// Each item goes from acceptance to the result register through an accept
// step, a walk over all slots through the slot store's single registered
// read port, a commit of the arm or disarm, and a test of the earliest
// expiry against the time counter. All expiry ordering goes through one shared
// less-than comparator. in_stall stays high from acceptance until the result
// is loaded; a new item may be taken while the previous result still waits
// behind out_stall. A tick adds one to the time counter (wrapping), an arm
// puts the line into the lowest free slot at now plus latency, a disarm frees
// the slot holding the line. Errors (zero latency, then duplicate line, then
// full table; disarm of a line not armed) leave the table unchanged. Expiries
// compare as plain unsigned values, ties go to the lowest slot, and
// ready_address shows the earliest line even while it is not yet due.
// ----------------------------------------------------------------------------
module earliest_deadline_timer_table_core #(
	parameter int ENTRIES      = edtt_pkg::ENTRIES_DEF,
	parameter int LINE_BITS    = edtt_pkg::LINE_BITS_DEF,
	parameter int TIME_BITS    = edtt_pkg::TIME_BITS_DEF,
	parameter int LATENCY_BITS = edtt_pkg::LATENCY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  edtt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output edtt_pkg::out_item_t out_data
);
	import edtt_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SCAN_W = $clog2(ENTRIES + 1);
	localparam int CNT_W  = SCAN_W;

	// sequencer
	edtt_state_e state_q, state_d;

	// item held for the whole walk
	logic [CMD_W-1:0]     cmd_q;
	logic [LINE_BITS-1:0] line_q;
	logic                 lat_zero_q;
	logic [TIME_BITS-1:0] new_exp_q;
	logic [TIME_BITS-1:0] now_q;

	// walk state
	logic [SCAN_W-1:0] scan_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  slot_s1;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_slot_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              any_q;
	logic [TIME_BITS-1:0] best_exp_q;
	logic [LINE_BITS-1:0] best_line_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [STATUS_W-1:0]  status_q;

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	// slot store port
	edtt_mem_ctl_t        mem_ctl;
	logic [IDX_W-1:0]     wr_addr;
	logic                 rd_vld;
	logic [LINE_BITS-1:0] rd_line;
	logic [TIME_BITS-1:0] rd_exp;

	// shared comparator
	logic [TIME_BITS-1:0] cmp_a, cmp_b;
	logic                 cmp_lt;

	logic                    accept;
	logic                    issue;
	logic                    load_out;
	logic [LATENCY_BITS-1:0] lat_in;
	logic                    hit_now;
	logic                    take;
	logic                    free_first;
	logic                    new_wins;
	logic                    arm_ok;
	logic                    dis_ok;
	edtt_status_e            sts;

	assign lat_in = LATENCY_BITS'(in_data.latency);
	assign accept = in_valid && !in_stall;

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// reads go out for slots 0..ENTRIES-1, the last one lands here
				issue = (scan_q != SCAN_W'(ENTRIES));
				if (!issue) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_DUE;
			end
			ST_DUE: begin
				// wait only if the previous result has not been taken yet
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- shared less-than unit ----
	// free slot below the current best: the new entry also wins a tie,
	// so test best < new and invert
	assign free_first = (free_slot_q < best_slot_q);

	always_comb begin
		case (state_q)
			ST_APPLY: begin
				if (free_first) begin
					cmp_a = best_exp_q;
					cmp_b = new_exp_q;
				end else begin
					cmp_a = new_exp_q;
					cmp_b = best_exp_q;
				end
			end
			ST_DUE: begin
				cmp_a = now_q;
				cmp_b = best_exp_q;
			end
			default: begin
				cmp_a = rd_exp;
				cmp_b = best_exp_q;
			end
		endcase
	end

	assign cmp_lt = (cmp_a < cmp_b);

	// ---- per-slot decisions during the walk ----
	assign hit_now = rd_vld && (rd_line == line_q);
	// a disarmed line drops out of the minimum right away; lines are unique
	assign take    = rd_vld && !((cmd_q == CMD_DISARM) && hit_now) && (!any_q || cmp_lt);

	// ---- commit decisions ----
	assign new_wins = !any_q || (free_first ? !cmp_lt : cmp_lt);
	assign arm_ok   = (cmd_q == CMD_ARM) && !lat_zero_q && !hit_q && free_q;
	assign dis_ok   = (cmd_q == CMD_DISARM) && hit_q;

	always_comb begin
		case (cmd_q)
			CMD_ARM: begin
				if (lat_zero_q) begin
					sts = STS_ZERO;
				end else if (hit_q) begin
					sts = STS_DUP;
				end else if (!free_q) begin
					sts = STS_FULL;
				end else begin
					sts = STS_OK;
				end
			end
			CMD_DISARM: begin
				sts = hit_q ? STS_OK : STS_MISSING;
			end
			default: begin
				sts = STS_OK;
			end
		endcase
	end

	always_comb begin
		mem_ctl.rd  = issue;
		mem_ctl.wr  = (state_q == ST_APPLY) && arm_ok;
		mem_ctl.clr = (state_q == ST_APPLY) && dis_ok;
		wr_addr     = arm_ok ? free_slot_q : hit_slot_q;
	end

	edtt_slot_mem #(
		.ENTRIES   (ENTRIES),
		.LINE_BITS (LINE_BITS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (scan_q[IDX_W-1:0]),
		.wr_addr (wr_addr),
		.wr_line (line_q),
		.wr_exp  (new_exp_q),
		.rd_vld  (rd_vld),
		.rd_line (rd_line),
		.rd_exp  (rd_exp)
	);

	// ---- control and counters ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			cmd_q       <= CMD_TICK;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			cnt_q       <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (accept) begin
				cmd_q  <= in_data.command;
				scan_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				cnt_q  <= '0;
				any_q  <= 1'b0;
				if (in_data.command == CMD_TICK) begin
					now_q <= now_q + TIME_BITS'(1);
				end
			end
			if (issue) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
			if (pend_s1) begin
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (!rd_vld) begin
					free_q <= 1'b1;
				end
				if (rd_vld) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (take) begin
					any_q <= 1'b1;
				end
			end
			if (state_q == ST_APPLY) begin
				if (arm_ok) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (new_wins) begin
						any_q <= 1'b1;
					end
				end else if (dis_ok) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q     <= LINE_BITS'(in_data.line_num);
			lat_zero_q <= (lat_in == '0);
			new_exp_q  <= TIME_BITS'(now_q + TIME_BITS'(lat_in));
		end
		if (issue) begin
			slot_s1 <= scan_q[IDX_W-1:0];
		end
		if (pend_s1) begin
			if (hit_now) begin
				hit_slot_q <= slot_s1;
			end
			// first empty slot seen is the lowest one
			if (!rd_vld && !free_q) begin
				free_slot_q <= slot_s1;
			end
			if (take) begin
				best_exp_q  <= rd_exp;
				best_line_q <= rd_line;
				best_slot_q <= slot_s1;
			end
		end
		if (state_q == ST_APPLY) begin
			status_q <= sts;
			if (arm_ok && new_wins) begin
				best_exp_q  <= new_exp_q;
				best_line_q <= line_q;
				best_slot_q <= free_slot_q;
			end
		end
		if (load_out) begin
			out_q.ready_res     <= any_q && !cmp_lt;
			out_q.ready_address <= any_q ? LINE_W'(best_line_q) : '0;
			out_q.status        <= status_q;
			out_q.occupancy     <= OCC_W'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/edtt_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtt_slot_mem
// slot store: line and expiry memory with registered read, armed bits in flops
// ----------------------------------------------------------------------------
module edtt_slot_mem #(
	parameter int ENTRIES   = edtt_pkg::ENTRIES_DEF,
	parameter int LINE_BITS = edtt_pkg::LINE_BITS_DEF,
	parameter int TIME_BITS = edtt_pkg::TIME_BITS_DEF,
	parameter int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  edtt_pkg::edtt_mem_ctl_t ctl,
	input  logic [IDX_W-1:0]       rd_addr,
	input  logic [IDX_W-1:0]       wr_addr,
	input  logic [LINE_BITS-1:0]   wr_line,
	input  logic [TIME_BITS-1:0]   wr_exp,
	output logic                   rd_vld,
	output logic [LINE_BITS-1:0]   rd_line,
	output logic [TIME_BITS-1:0]   rd_exp
);
	import edtt_pkg::*;

	logic [LINE_BITS-1:0] line_mem [ENTRIES];
	logic [TIME_BITS-1:0] exp_mem  [ENTRIES];
	logic [ENTRIES-1:0]   armed_q;
	logic                 rd_vld_q;
	logic [LINE_BITS-1:0] rd_line_q;
	logic [TIME_BITS-1:0] rd_exp_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			line_mem[wr_addr] <= wr_line;
			exp_mem[wr_addr]  <= wr_exp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_line_q <= line_mem[rd_addr];
			rd_exp_q  <= exp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				armed_q[wr_addr] <= 1'b1;
			end else if (ctl.clr) begin
				armed_q[wr_addr] <= 1'b0;
			end
			if (ctl.rd) begin
				rd_vld_q <= armed_q[rd_addr];
			end
		end
	end

	assign rd_vld  = rd_vld_q;
	assign rd_line = rd_line_q;
	assign rd_exp  = rd_exp_q;

endmodule

### hdl/edtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtt_checker
// port-level checks on the earliest deadline timer table, bound to the top
// ----------------------------------------------------------------------------
`include "earliest_deadline_timer_table_core_macros.svh"

module edtt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input edtt_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input edtt_pkg::out_item_t out_data
);
	import edtt_pkg::*;

	// a waiting input item holds
	`EDTT_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
	// one item at a time: busy right after taking an item
	`EDTT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// a stalled result holds
	`EDTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	// a fresh result comes with the input side open again
	`EDTT_ASSERT_IMP(a_result_frees_input, $rose(out_valid), !in_stall)
	// only defined status codes
	`EDTT_ASSERT_IMP(a_status_code, out_valid, out_data.status <= STS_MISSING)

endmodule

bind earliest_deadline_timer_table_core edtt_checker u_edtt_checker (.*);

### tb/earliest_deadline_timer_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_deadline_timer_table_core_test
// drives tick, arm, disarm and unused commands through the valid/stall input
// channel, predicts every timer report in the testbench and checks each one
// as it leaves the output channel, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module earliest_deadline_timer_table_core_test;

	import edtt_pkg::*;

	localparam int ENTRIES   = ENTRIES_DEF;
	localparam int TIME_BITS = TIME_BITS_DEF;

	// command code the block has no operation for
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
	localparam logic [LAT_W-1:0]  LAT_MAX  = {LAT_W{1'b1}};

	localparam int POOL_SIZE    = 20;
	localparam int BLOCKS       = 10;
	localparam int BLOCK_ITEMS  = 100;
	localparam int SETTLE_TICKS = 40;

	typedef struct {
		in_item_t  stim;
		bit        typed;   // expected report written into the row
		out_item_t report;
	} directed_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	// predictor copy of the timer table
	logic                 armed        [ENTRIES];
	logic [LINE_W-1:0]    armed_line   [ENTRIES];
	logic [TIME_BITS-1:0] armed_expiry [ENTRIES];
	logic [TIME_BITS-1:0] now_ticks;

	out_item_t     timer_reports[$];   // reports still owed by the block
	directed_row_t rows[$];
	logic [LINE_W-1:0] line_pool [POOL_SIZE];

	bit no_idle;        // both sides run flat out while set
	int mismatches;
	int reports_seen;

	earliest_deadline_timer_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("earliest_deadline_timer_table_core: mismatch");
		$finish;
	end

	// apply one item to the table copy and build the report that follows it
	function automatic out_item_t next_timer_report(in_item_t it);
		out_item_t            rep;
		edtt_status_e         sts;
		int                   hit;
		int                   free_slot;
		int                   count;
		bit                   found;
		logic [TIME_BITS-1:0] best;
		sts       = STS_OK;
		hit       = -1;
		free_slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (armed[i] && armed_line[i] == it.line_num && hit < 0)
				hit = i;
			if (!armed[i] && free_slot < 0)
				free_slot = i;
		end
		case (it.command)
			CMD_TICK: begin
				now_ticks = now_ticks + 1'b1;
			end
			CMD_ARM: begin
				// zero latency beats duplicate, duplicate beats full
				if (it.latency == '0)
					sts = STS_ZERO;
				else if (hit >= 0)
					sts = STS_DUP;
				else if (free_slot < 0)
					sts = STS_FULL;
				else begin
					armed[free_slot]        = 1'b1;
					armed_line[free_slot]   = it.line_num;
					armed_expiry[free_slot] = now_ticks + TIME_BITS'(it.latency);
				end
			end
			CMD_DISARM: begin
				if (hit < 0)
					sts = STS_MISSING;
				else
					armed[hit] = 1'b0;
			end
			default: ;
		endcase
		// earliest expiry, plain unsigned compare, lowest slot wins a tie
		rep   = '0;
		count = 0;
		found = 1'b0;
		best  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (armed[i]) begin
				count++;
				if (!found || armed_expiry[i] < best) begin
					found             = 1'b1;
					best              = armed_expiry[i];
					rep.ready_address = armed_line[i];
				end
			end
		end
		rep.ready_res = found && now_ticks >= best;
		rep.status    = sts;
		rep.occupancy = OCC_W'(count);
		return rep;
	endfunction

	function automatic void add_row(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] line,
			logic [LAT_W-1:0] lat);
		directed_row_t row;
		row.stim   = '{command: cmd, line_num: line, latency: lat};
		row.typed  = 1'b0;
		row.report = '0;
		rows.push_back(row);
	endfunction

	function automatic void add_checked_row(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] line,
			logic [LAT_W-1:0] lat, logic ready, logic [LINE_W-1:0] addr, edtt_status_e sts,
			int occ);
		directed_row_t row;
		row.stim   = '{command: cmd, line_num: line, latency: lat};
		row.typed  = 1'b1;
		row.report = '{ready_res: ready, ready_address: addr, status: sts,
			occupancy: OCC_W'(occ)};
		rows.push_back(row);
	endfunction

	// present one item, hold it until taken, then log what it should produce
	task automatic offer_item(in_item_t it, bit typed, out_item_t typed_report);
		int        gap;
		out_item_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		predicted = next_timer_report(it);
		timer_reports.push_back(typed ? typed_report : predicted);
	endtask

	// hold the input side quiet until every owed report is out
	task automatic drain_reports();
		in_valid <= 1'b0;
		do @(posedge clk); while (timer_reports.size() != 0);
	endtask

	function automatic in_item_t random_item(int arm_w, int disarm_w);
		in_item_t it;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			it.command = CMD_UNUSED;
		else if (pick < 4 + arm_w)
			it.command = CMD_ARM;
		else if (pick < 4 + arm_w + disarm_w)
			it.command = CMD_DISARM;
		else
			it.command = CMD_TICK;
		// mostly lines from a small pool so duplicates and disarms land
		if ($urandom_range(0, 99) < 85)
			it.line_num = line_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			it.line_num = LINE_W'($urandom());
		// short latencies so ticks bring entries due
		pick = $urandom_range(0, 99);
		if (pick < 60)
			it.latency = LAT_W'($urandom_range(1, 24));
		else if (pick < 70)
			it.latency = '0;
		else if (pick < 80)
			it.latency = LAT_MAX;
		else
			it.latency = LAT_W'($urandom());
		return it;
	endfunction

	// output side: random stall before each report, none while no_idle is set
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare every report taken with the oldest one owed
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (timer_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %0d none owed: rdy %0b line %h sts %0d occ %0d",
						reports_seen, out_data.ready_res, out_data.ready_address,
						out_data.status, out_data.occupancy);
			end else begin
				want = timer_reports.pop_front();
				if (out_data.ready_res !== want.ready_res
						|| out_data.ready_address !== want.ready_address
						|| out_data.status !== want.status
						|| out_data.occupancy !== want.occupancy) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("report %0d want: rdy %0b line %h sts %0d occ %0d",
							reports_seen, want.ready_res, want.ready_address,
							want.status, want.occupancy);
						$display("report %0d got:  rdy %0b line %h sts %0d occ %0d",
							reports_seen, out_data.ready_res, out_data.ready_address,
							out_data.status, out_data.occupancy);
					end
				end
			end
		end
	end

	initial begin
		int arm_w;
		int disarm_w;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		no_idle      = 1'b0;
		mismatches   = 0;
		reports_seen = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			armed[i]        = 1'b0;
			armed_line[i]   = '0;
			armed_expiry[i] = '0;
		end
		now_ticks = '0;

		// directed rows, time starts at zero
		add_checked_row(CMD_TICK,   '0,       '0,      1'b0, '0,       STS_OK,      0);
		add_checked_row(CMD_DISARM, LINE_MAX, '0,      1'b0, '0,       STS_MISSING, 0);
		add_checked_row(CMD_ARM,    26'd5,    '0,      1'b0, '0,       STS_ZERO,    0);
		add_checked_row(CMD_ARM,    LINE_MAX, LAT_MAX, 1'b0, LINE_MAX, STS_OK,      1);
		add_checked_row(CMD_ARM,    '0,       16'd1,   1'b0, '0,       STS_OK,      2);
		add_checked_row(CMD_ARM,    '0,       16'd3,   1'b0, '0,       STS_DUP,     2);
		// line zero falls due exactly now
		add_checked_row(CMD_TICK,   '0,       '0,      1'b1, '0,       STS_OK,      2);
		add_checked_row(CMD_UNUSED, 26'h2AAAAAA, 16'h5555, 1'b1, '0,   STS_OK,      2);
		// two entries on the same expiry, then line zero goes away
		add_row(CMD_ARM,    26'h1555555, 16'd1);
		add_row(CMD_ARM,    26'd7,       16'd1);
		add_row(CMD_DISARM, '0,          '0);
		// fill every slot
		for (int k = 0; k < ENTRIES - 3; k++)
			add_row(CMD_ARM, LINE_W'(26'h100 + k), LAT_W'(1000 + k));
		add_checked_row(CMD_ARM, 26'h200, 16'd5, 1'b0, 26'h1555555, STS_FULL, ENTRIES);
		add_checked_row(CMD_ARM, 26'h200, '0,    1'b0, 26'h1555555, STS_ZERO, ENTRIES);
		add_checked_row(CMD_ARM, 26'd7,   16'd9, 1'b0, 26'h1555555, STS_DUP,  ENTRIES);
		add_row(CMD_TICK, LINE_MAX, LAT_MAX);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r])
			offer_item(rows[r].stim, rows[r].typed, rows[r].report);

		// let every owed report out of the pipe before the random part
		drain_reports();

		for (int blk = 0; blk < BLOCKS; blk++) begin
			// each block gets its own line pool and command mix
			for (int p = 0; p < POOL_SIZE; p++)
				line_pool[p] = LINE_W'($urandom());
			if (blk % 2 == 0) begin
				line_pool[0] = '0;
				line_pool[1] = LINE_MAX;
			end
			case (blk % 4)
				0: begin arm_w = 35; disarm_w = 20; end
				1: begin arm_w = 60; disarm_w = 8;  end   // pushes the table full
				2: begin arm_w = 20; disarm_w = 45; end   // drains it again
				default: begin arm_w = 45; disarm_w = 15; end
			endcase
			no_idle = (blk % 3 == 2);
			if (blk == BLOCKS / 2)
				drain_reports();
			for (int n = 0; n < BLOCK_ITEMS; n++)
				offer_item(random_item(arm_w, disarm_w), 1'b0, '0);
		end
		in_valid <= 1'b0;
		no_idle  = 1'b0;

		while (timer_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		if (mismatches == 0 && timer_reports.size() == 0)
			$display("earliest_deadline_timer_table_core: match");
		else
			$display("earliest_deadline_timer_table_core: mismatch");
		$finish;
	end

endmodule
